@@ rtl/core/mwr_pkg.sv @@
// Shared constants for the masked window reduction block.
package mwr_pkg;

    // Sample and result width, signed Q16.16
    localparam int DATA_W = 32;

    // Default window length limit in valid samples
    localparam int MAX_WINDOW_DEF = 4096;

    // Configuration data and address widths
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Reduction kinds; the unused code falls back to the mean
    localparam logic [1:0] MODE_MEAN = 2'd0;
    localparam logic [1:0] MODE_MAX  = 2'd1;
    localparam logic [1:0] MODE_MIN  = 2'd2;

    // Register indexes
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_NODATA = 1'b1;

endpackage

@@ rtl/core/mwr_if.sv @@
// Stream interfaces for sample words in and result words out.
interface mwr_in_if;
    import mwr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample;
    logic                     last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface mwr_out_if #(
    parameter int CNT_W = $clog2(mwr_pkg::MAX_WINDOW_DEF + 1)
);
    import mwr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result;
    logic                     no_valid;
    logic [CNT_W-1:0]         valid_count;

    modport source (output valid, output result, output no_valid, output valid_count,
                    input ready);
    modport sink   (input valid, input result, input no_valid, input valid_count,
                    output ready);
endinterface

@@ rtl/core/masked_window_reduce_top.sv @@
// Masked window reduction: mean, maximum or minimum of the non-marker samples.
// A sample word that does not close its window is taken while the sequencer is idle; one adder does the add.
// Closing in max/min, empty window or zero sum: no divide; S_OUT then loads the output register.
// Closing in mean mode: accept, magnitude, SUM_W divide steps, sign, then the output load
// (SUM_W = 32 + clog2(MAX_WINDOW), 44 at the default); a full output stretches the load.
// Reset is synchronous, active low: clears the window, the config registers, the sequencer and the output valid.
module masked_window_reduce_top #(
    parameter int MAX_WINDOW = mwr_pkg::MAX_WINDOW_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mwr_in_if.sink                           i_in_ch,
    mwr_out_if.source                        o_out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mwr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [mwr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [mwr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import mwr_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = DATA_W + $clog2(MAX_WINDOW);
    localparam int AW     = SUM_W + 1;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_WINDOW);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ABS  = 5'b00010,
        S_DIV  = 5'b00100,
        S_NEG  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                   r_state;
    logic [1:0]               r_mode;
    logic signed [DATA_W-1:0] r_nodata;
    logic [SUM_W-1:0]         r_sum;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [DATA_W-1:0] r_ext;
    logic [SUM_W-1:0]         r_quo;
    logic [CNT_W-1:0]         r_rem;
    logic [STEP_W-1:0]        r_step;
    logic                     r_neg;
    logic                     r_empty;
    logic signed [DATA_W-1:0] r_res;
    logic                     r_oval;
    logic signed [DATA_W-1:0] r_out_res;
    logic                     r_out_nov;
    logic [CNT_W-1:0]         r_out_cnt;

    logic [SUM_W-1:0]         n_sum;
    logic [CNT_W-1:0]         n_cnt;
    logic signed [DATA_W-1:0] n_ext;

    logic [AW-1:0]            a_op;
    logic [AW-1:0]            b_op;
    logic                     cin;
    logic [AW-1:0]            add_y;
    logic [CNT_W:0]           rem_sh;
    logic                     diff_neg;
    logic                     take;
    logic                     acc;
    logic                     cfg_wr;
    logic                     out_free;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        if (paddr[2] == REG_NODATA) begin
            prdata = r_nodata;
        end else begin
            prdata = {{(CFG_DATA_W-2){1'b0}}, r_mode};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_MEAN;
            r_nodata <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_NODATA) begin
                r_nodata <= pwdata;
            end else begin
                r_mode <= pwdata[1:0];
            end
        end
    end

    // Input handshake and sample qualification
    assign i_in_ch.ready = (r_state == S_IDLE);
    assign acc  = i_in_ch.valid && (r_state == S_IDLE);
    assign take = acc && (i_in_ch.sample != r_nodata) && (r_cnt < CNT_MAX);

    // Divider shift of the partial remainder
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};

    // Shared adder: accumulate, magnitude, trial subtract, sign restore
    always_comb begin
        a_op = '0;
        b_op = '0;
        cin  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                a_op = {{(AW-SUM_W){r_sum[SUM_W-1]}}, r_sum};
                b_op = {{(AW-DATA_W){i_in_ch.sample[DATA_W-1]}}, i_in_ch.sample};
            end
            S_ABS: begin
                b_op = ~{{(AW-SUM_W){r_sum[SUM_W-1]}}, r_sum};
                cin  = 1'b1;
            end
            S_DIV: begin
                a_op = {{(AW-CNT_W-1){1'b0}}, rem_sh};
                b_op = ~{{(AW-CNT_W){1'b0}}, r_cnt};
                cin  = 1'b1;
            end
            S_NEG: begin
                b_op = ~{{(AW-SUM_W){1'b0}}, r_quo};
                cin  = 1'b1;
            end
            S_OUT: begin
                a_op = '0;
            end
            default: begin
                a_op = '0;
            end
        endcase
    end

    assign add_y    = a_op + b_op + {{(AW-1){1'b0}}, cin};
    assign diff_neg = add_y[AW-1];

    // Window update for the sample now at the input
    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        n_ext = r_ext;
        if (take) begin
            n_sum = add_y[SUM_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == '0) begin
                n_ext = i_in_ch.sample;
            end else if (r_mode == MODE_MAX) begin
                if (i_in_ch.sample > r_ext) begin
                    n_ext = i_in_ch.sample;
                end
            end else if (r_mode == MODE_MIN) begin
                if (i_in_ch.sample < r_ext) begin
                    n_ext = i_in_ch.sample;
                end
            end
        end
    end

    // Output register
    assign out_free             = !r_oval || o_out_ch.ready;
    assign o_out_ch.valid       = r_oval;
    assign o_out_ch.result      = r_out_res;
    assign o_out_ch.no_valid    = r_out_nov;
    assign o_out_ch.valid_count = r_out_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_oval <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_res <= r_res;
            r_out_nov <= r_empty;
            r_out_cnt <= r_cnt;
        end
    end

    // Sequencer and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_ext   <= '0;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_sum <= n_sum;
                        r_cnt <= n_cnt;
                        r_ext <= n_ext;
                        if (i_in_ch.last_sample) begin
                            r_empty <= (n_cnt == '0);
                            r_neg   <= n_sum[SUM_W-1];
                            if (n_cnt == '0) begin
                                r_res   <= r_nodata;
                                r_state <= S_OUT;
                            end else if (r_mode == MODE_MAX || r_mode == MODE_MIN) begin
                                r_res   <= n_ext;
                                r_state <= S_OUT;
                            end else if (n_sum == '0) begin
                                r_res   <= r_nodata;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_ABS;
                            end
                        end
                    end
                end
                S_ABS: begin
                    r_quo   <= r_neg ? add_y[SUM_W-1:0] : r_sum;
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_quo <= {r_quo[SUM_W-2:0], ~diff_neg};
                    r_rem <= diff_neg ? rem_sh[CNT_W-1:0] : add_y[CNT_W-1:0];
                    if (r_step == STEP_LAST) begin
                        r_state <= S_NEG;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_NEG: begin
                    r_res   <= r_neg ? add_y[DATA_W-1:0] : r_quo[DATA_W-1:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_ext   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
